### src/aco_pkg.sv
// package: types, constants and command codes for the pheromone update block
`default_nettype none
package aco_pkg;
  localparam int NumVars   = 16;
  localparam int NumValues = 16;
  localparam int NumAnts   = 16;
  localparam int VarW      = 4;
  localparam int ValW      = 4;
  localparam int SlotW     = 5;
  localparam int TabDepth  = NumVars * NumValues;
  localparam int TabAw     = VarW + ValW;
  localparam int PathDepth = (NumAnts + 1) * NumVars;
  localparam int PathAw    = 9;
  localparam int QDepth    = 4;
  localparam int QAw       = 2;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_AS  = 2'd0,
    MODE_EAS = 2'd1,
    MODE_RAS = 2'd2,
    MODE_ACS = 2'd3
  } mode_t;

  localparam logic [2:0] REG_INIT  = 3'd0;
  localparam logic [2:0] REG_EVAP  = 3'd1;
  localparam logic [2:0] REG_MODE  = 3'd2;
  localparam logic [2:0] REG_ELITE = 3'd3;
  localparam logic [2:0] REG_RANK  = 3'd4;
  localparam logic [2:0] REG_VARS  = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  ant_slot;
    logic [3:0]  var_index;
    logic [3:0]  value_index;
    logic [31:0] cost;
  } in_item_t;

  typedef struct packed {
    logic [31:0] trail_value;
    logic        done_res;
  } out_item_t;

  // classified work passed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  ant_slot;
    logic [3:0]  var_index;
    logic [3:0]  value_index;
    logic [31:0] cost;
    logic        in_range;
  } job_t;

  typedef struct packed {
    logic [31:0] init_level;
    logic [15:0] evap_rate;
    logic [1:0]  update_mode;
    logic [7:0]  elite_weight;
    logic [4:0]  rank_count;
    logic [4:0]  vars_in_use;
  } cfg_t;
endpackage
`default_nettype wire

### src/aco_ram.sv
// generic single-port-write, single-read ram with registered read
`default_nettype none
module aco_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/aco_front.sv
// front end: accepts items, classifies and queues jobs
`default_nettype none
module aco_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire aco_pkg::in_item_t in_item,
  output logic                   job_valid,
  input  wire logic              job_ready,
  output aco_pkg::job_t          job
);
  import aco_pkg::*;

  job_t         q [QDepth];
  logic [QAw-1:0] wp, rp;
  logic [QAw:0] cnt;
  logic         push, pop;
  job_t         nj;

  assign in_ready  = (cnt != QDepth[QAw:0]);
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt != '0);
  assign pop       = job_valid && job_ready;
  assign job       = q[rp];

  always_comb begin
    nj.cmd         = cmd_t'(in_item.cmd);
    nj.ant_slot    = in_item.ant_slot;
    nj.var_index   = in_item.var_index;
    nj.value_index = in_item.value_index;
    nj.cost        = in_item.cost;
    nj.in_range    = (in_item.ant_slot <= SlotW'(NumAnts));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= nj;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + {{QAw{1'b0}}, push} - {{QAw{1'b0}}, pop};
    end
  end
endmodule
`default_nettype wire

### src/aco_back.sv
// back end: sequencer that walks the table for init, update, load and read
`default_nettype none
module aco_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire aco_pkg::cfg_t     cfg,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire aco_pkg::job_t     job,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output aco_pkg::out_item_t     out_item
);
  import aco_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_INIT  = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_RDW   = 11'b00000001000,
    S_EVR   = 11'b00000010000,
    S_EVW   = 11'b00000100000,
    S_PLAN  = 11'b00001000000,
    S_DPP   = 11'b00010000000,
    S_DPT   = 11'b00100000000,
    S_DPW   = 11'b01000000000,
    S_RANK  = 11'b10000000000
  } state_t;

  state_t        state;
  logic [31:0]   costs [NumAnts+1];
  logic [NumAnts-1:0] taken;
  logic [TabAw:0] idx;
  logic [4:0]    nv;
  logic [4:0]    slot;
  logic [4:0]    v;
  logic [7:0]    weight;
  logic [4:0]    step;
  logic [4:0]    rsc;
  logic [4:0]    best;
  logic          found;
  logic [3:0]    chosen;
  logic [16:0]   keep;
  logic [47:0]   prod;
  logic          have_res;
  logic [31:0]   res_val;

  logic          t_we;
  logic [TabAw-1:0] t_wa, t_ra;
  logic [31:0]   t_wd, t_rd;
  logic          p_we;
  logic [PathAw-1:0] p_wa, p_ra;
  logic [3:0]    p_rd;

  aco_ram #(.Width(32), .Depth(TabDepth)) u_tab (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  aco_ram #(.Width(4), .Depth(PathDepth)) u_path (
    .clk, .we(p_we), .waddr(p_wa), .wdata(job.value_index), .raddr(p_ra),
    .rdata(p_rd));

  assign nv   = (cfg.vars_in_use > 5'(NumVars)) ? 5'(NumVars) : cfg.vars_in_use;
  assign keep = 17'h10000 - {1'b0, cfg.evap_rate};
  assign prod = {16'h0, t_rd} * {31'h0, keep};
  assign job_ready = (state == S_IDLE) && !have_res;
  assign out_valid = have_res;
  assign out_item.trail_value = res_val;
  assign out_item.done_res = 1'b1;

  logic take;
  assign take = job_valid && job_ready;

  assign p_we = take && job.cmd == CMD_LOAD && job.in_range;
  assign p_wa = PathAw'(job.ant_slot * NumVars + job.var_index);
  assign p_ra = PathAw'(slot * NumVars + v[3:0]);

  logic [32:0] dsum;
  assign dsum = {1'b0, t_rd} + {1'b0, weight, 16'h0};

  always_comb begin
    t_we = 1'b0;
    t_wa = idx[TabAw-1:0];
    t_wd = cfg.init_level;
    t_ra = idx[TabAw-1:0];
    case (state)
      S_IDLE: t_ra = {job.var_index, job.value_index};
      S_INIT: t_we = (idx[TabAw-1:VarW] < nv[3:0]) || nv[4];
      S_EVW: begin
        t_we = 1'b1;
        t_wd = prod[47:16];
      end
      S_DPT: t_ra = {v[3:0], p_rd};
      S_DPW: begin
        t_we = !(weight == 8'd0);
        t_wa = {v[3:0], chosen};
        t_wd = dsum[32] ? 32'hFFFFFFFF : dsum[31:0];
      end
      default: ;
    endcase
  end

  // choose next deposit after finishing one ant
  logic [4:0]  rank_left;
  assign rank_left = cfg.rank_count - step - 5'd1;

  always_ff @(posedge clk) begin
    if (p_we) begin
      costs[job.ant_slot] <= job.cost;
    end
    if (rst) begin
      state    <= S_IDLE;
      have_res <= 1'b0;
      res_val  <= '0;
      taken    <= '0;
      idx      <= '0;
      slot <= '0; v <= '0; weight <= '0; step <= '0; rsc <= '0; best <= '0;
      found <= 1'b0; chosen <= '0;
    end else begin
      if (out_valid && out_ready) have_res <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            idx <= (job.cmd == CMD_READ) ? {1'b0, job.var_index, job.value_index} : '0;
            res_val <= '0;
            step <= '0;
            taken <= '0;
            case (job.cmd)
              CMD_INIT:   state <= S_INIT;
              CMD_UPDATE: state <= (nv == 5'd0) ? S_PLAN : S_EVR;
              CMD_READ:   state <= S_RD;
              default:    have_res <= 1'b1;
            endcase
          end
        end
        S_INIT: begin
          idx <= idx + 1'b1;
          if (idx == (TabAw+1)'(TabDepth - 1)) begin
            state <= S_IDLE;
            have_res <= 1'b1;
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          res_val  <= t_rd;
          have_res <= 1'b1;
          state    <= S_IDLE;
        end
        S_EVR: state <= S_EVW;
        S_EVW: begin
          if (idx[TabAw-1:0] == TabAw'(TabDepth - 1) ||
              idx[TabAw-1:0] + 1'b1 == {nv[3:0], 4'h0}) begin
            state <= S_PLAN;
            step  <= '0;
            slot  <= '0;
            taken <= '0;
          end else begin
            state <= S_EVR;
          end
          idx <= idx + 1'b1;
        end
        S_PLAN: begin
          v <= '0;
          case (mode_t'(cfg.update_mode))
            MODE_AS, MODE_EAS: begin
              if (step < 5'(NumAnts)) begin
                slot <= step; weight <= 8'd1; state <= S_DPP;
              end else if (cfg.update_mode == MODE_EAS && step == 5'(NumAnts)) begin
                slot <= 5'(NumAnts); weight <= cfg.elite_weight; state <= S_DPP;
              end else begin
                have_res <= 1'b1; state <= S_IDLE;
              end
            end
            MODE_RAS: begin
              if (step != 5'd31 && {1'b0, step} + 6'd1 < {1'b0, cfg.rank_count} &&
                  ~&taken) begin
                rsc <= '0; found <= 1'b0; state <= S_RANK;
              end else if (step != 5'd31) begin
                slot <= 5'(NumAnts); weight <= {3'b0, cfg.rank_count};
                step <= 5'd31; state <= S_DPP;
              end else begin
                have_res <= 1'b1; state <= S_IDLE;
              end
            end
            default: begin
              if (step == 5'd0) begin
                slot <= 5'(NumAnts); weight <= 8'd1; state <= S_DPP;
              end else begin
                have_res <= 1'b1; state <= S_IDLE;
              end
            end
          endcase
        end
        S_RANK: begin
          if (!taken[rsc[3:0]] && (!found || costs[rsc] < costs[best])) begin
            best <= rsc; found <= 1'b1;
          end
          if (rsc == 5'(NumAnts - 1)) begin
            state <= S_DPP;
            slot  <= (!taken[rsc[3:0]] && (!found || costs[rsc] < costs[best]))
                     ? rsc : best;
            taken[(!taken[rsc[3:0]] && (!found || costs[rsc] < costs[best]))
                  ? rsc[3:0] : best[3:0]] <= 1'b1;
            weight <= {3'b0, rank_left};
          end
          rsc <= rsc + 1'b1;
        end
        S_DPP: begin
          if (v >= nv) begin
            state <= S_PLAN;
            if (!(cfg.update_mode == MODE_RAS && step == 5'd31)) step <= step + 1'b1;
          end else begin
            state <= S_DPT;
          end
        end
        S_DPT: begin
          chosen <= p_rd;
          state  <= S_DPW;
        end
        S_DPW: begin
          v <= v + 1'b1;
          state <= S_DPP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/aco_pheromone_update.sv
// top level of the ant-colony pheromone table block
//
//  channel | signals                      | role
//  in      | in_valid in_ready in_item     | commands from the ant generator
//  out     | out_valid out_ready out_item  | one transaction per command
//  cfg     | cfg_we cfg_index cfg_data     | register writes
//
// load writes path memory; read passes S_RD, S_RDW; init walks 256 entries.
// update: evaporation reads and writes each entry in use (S_EVR, S_EVW); each
// deposit runs S_DPP, S_DPT, S_DPW per variable; a rank search scans 16 ants.
// reset is synchronous; the tables need an initialize before use.
// a 4-deep job queue lets the input side run while the back end is busy.
`default_nettype none
module aco_pheromone_update (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire aco_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output aco_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import aco_pkg::*;

  cfg_t cfg;
  job_t job;
  logic job_valid, job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_level   <= 32'd65536;
      cfg.evap_rate    <= 16'd6554;
      cfg.update_mode  <= 2'd0;
      cfg.elite_weight <= 8'd1;
      cfg.rank_count   <= 5'd6;
      cfg.vars_in_use  <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT:  cfg.init_level   <= cfg_data;
        REG_EVAP:  cfg.evap_rate    <= cfg_data[15:0];
        REG_MODE:  cfg.update_mode  <= cfg_data[1:0];
        REG_ELITE: cfg.elite_weight <= cfg_data[7:0];
        REG_RANK:  cfg.rank_count   <= cfg_data[4:0];
        REG_VARS:  cfg.vars_in_use  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  aco_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .job_valid, .job_ready, .job);

  aco_back u_back (
    .clk, .rst, .cfg, .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .out_item);
endmodule
`default_nettype wire

### tb/tb_aco_pheromone_update.sv
// testbench for the pheromone update block: self-checking against a built-in table predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_aco_pheromone_update;
  import aco_pkg::*;

  localparam int CycleLimit = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  aco_pheromone_update i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] trail_tab [NumVars][NumValues];
  logic [3:0]  ant_path [NumAnts+1][NumVars];
  logic [31:0] ant_cost [NumAnts+1];
  cfg_t        cur_cfg;

  out_item_t   expected_q[$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_updates = 0;
  int          cycles = 0;
  int          long_hold = 0;
  int          ready_gap = 0;
  bit          no_idle = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int used_vars();
    return (cur_cfg.vars_in_use > NumVars) ? NumVars : int'(cur_cfg.vars_in_use);
  endfunction

  function automatic void add_deposit(int slot, longint unsigned weight);
    longint unsigned s;
    for (int v = 0; v < used_vars(); v++) begin
      s = longint'(trail_tab[v][ant_path[slot][v]]) + weight * 64'd65536;
      trail_tab[v][ant_path[slot][v]] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    end
  endfunction

  function automatic void evaporate_and_deposit();
    longint unsigned keep;
    bit taken [NumAnts];
    bit found;
    int best;
    int rc;
    keep = 64'd65536 - longint'(cur_cfg.evap_rate);
    for (int v = 0; v < used_vars(); v++)
      for (int c = 0; c < NumValues; c++)
        trail_tab[v][c] = 32'((longint'(trail_tab[v][c]) * keep) >> 16);
    case (mode_t'(cur_cfg.update_mode))
      MODE_AS: for (int a = 0; a < NumAnts; a++) add_deposit(a, 1);
      MODE_EAS: begin
        for (int a = 0; a < NumAnts; a++) add_deposit(a, 1);
        add_deposit(NumAnts, cur_cfg.elite_weight);
      end
      MODE_RAS: begin
        rc = cur_cfg.rank_count;
        for (int a = 0; a < NumAnts; a++) taken[a] = 0;
        for (int i = 0; i + 1 < rc; i++) begin
          found = 0;
          best = 0;
          for (int a = 0; a < NumAnts; a++) begin
            if (!taken[a] && (!found || ant_cost[a] < ant_cost[best])) begin
              best = a;
              found = 1;
            end
          end
          if (!found) break;
          taken[best] = 1;
          add_deposit(best, rc - i - 1);
        end
        add_deposit(NumAnts, rc);
      end
      default: add_deposit(NumAnts, 1);
    endcase
  endfunction

  function automatic out_item_t table_command(in_item_t it);
    out_item_t r;
    r.trail_value = '0;
    r.done_res = 1'b1;
    case (cmd_t'(it.cmd))
      CMD_INIT:
        for (int v = 0; v < used_vars(); v++)
          for (int c = 0; c < NumValues; c++) trail_tab[v][c] = cur_cfg.init_level;
      CMD_LOAD:
        if (it.ant_slot <= NumAnts) begin
          ant_path[it.ant_slot][it.var_index] = it.value_index;
          ant_cost[it.ant_slot] = it.cost;
        end
      CMD_UPDATE: evaporate_and_deposit();
      default: r.trail_value = trail_tab[it.var_index][it.value_index];
    endcase
    return r;
  endfunction

  task automatic send_item(in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(table_command(it));
    n_sent++;
    if (cmd_t'(it.cmd) == CMD_UPDATE) n_updates++;
  endtask

  task automatic send_cmd(cmd_t c, int slot, int vi, int ci, logic [31:0] cost);
    in_item_t it;
    it.cmd = c;
    it.ant_slot = slot;
    it.var_index = vi;
    it.value_index = ci;
    it.cost = cost;
    send_item(it);
  endtask

  task automatic wait_idle();
    if (n_sent > 0) in_valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INIT:  cur_cfg.init_level = val;
      REG_EVAP:  cur_cfg.evap_rate = val[15:0];
      REG_MODE:  cur_cfg.update_mode = val[1:0];
      REG_ELITE: cur_cfg.elite_weight = val[7:0];
      REG_RANK:  cur_cfg.rank_count = val[4:0];
      default:   cur_cfg.vars_in_use = val[4:0];
    endcase
  endtask

  task automatic set_config(logic [31:0] lvl, logic [15:0] ev, mode_t m, logic [7:0] el,
                            logic [4:0] rk, logic [4:0] nv);
    wait_idle();
    write_reg(REG_INIT, lvl);
    write_reg(REG_EVAP, ev);
    write_reg(REG_MODE, m);
    write_reg(REG_ELITE, el);
    write_reg(REG_RANK, rk);
    write_reg(REG_VARS, nv);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      send_cmd(CMD_LOAD, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
               : $urandom_range(0, NumAnts), $urandom_range(0, 15), $urandom_range(0, 15),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom());
    else if (r < 85)
      send_cmd(CMD_READ, $urandom_range(0, 31), $urandom_range(0, 15),
               $urandom_range(0, 15), $urandom());
    else if (r < 95)
      send_cmd(CMD_UPDATE, $urandom_range(0, 31), $urandom_range(0, 15),
               $urandom_range(0, 15), $urandom());
    else
      send_cmd(CMD_INIT, $urandom_range(0, 31), $urandom_range(0, 15),
               $urandom_range(0, 15), $urandom());
  endtask

  // every path and cost is written before any update can use it
  task automatic test_setup();
    set_config(32'h0001_0000, 16'd6554, MODE_AS, 8'd1, 5'd6, 5'd16);
    send_cmd(CMD_INIT, 0, 0, 0, 32'd0);
    for (int a = 0; a <= NumAnts; a++)
      for (int v = 0; v < NumVars; v++)
        send_cmd(CMD_LOAD, a, v, $urandom_range(0, 15), $urandom_range(0, 1000));
  endtask

  task automatic test_directed();
    send_cmd(CMD_READ, 0, 0, 0, 32'd0);
    send_cmd(CMD_READ, 31, 15, 15, 32'hFFFF_FFFF);
    send_cmd(CMD_LOAD, 17, 3, 4, 32'd0);
    send_cmd(CMD_LOAD, 31, 15, 15, 32'hFFFF_FFFF);
    send_cmd(CMD_LOAD, 0, 15, 15, 32'hFFFF_FFFF);
    send_cmd(CMD_LOAD, NumAnts, 0, 0, 32'd0);
    for (int m = 0; m < 4; m++) begin
      set_config(32'hFFFF_FFFF, 16'd0, mode_t'(m), 8'd255, 5'd17, 5'd16);
      send_cmd(CMD_INIT, 0, 0, 0, 32'd0);
      send_cmd(CMD_UPDATE, 0, 0, 0, 32'd0);
      send_cmd(CMD_READ, 0, 15, 15, 32'd0);
      send_cmd(CMD_READ, 0, 0, 0, 32'd0);
    end
    set_config(32'h0000_0000, 16'hFFFF, MODE_RAS, 8'd0, 5'd1, 5'd1);
    send_cmd(CMD_INIT, 0, 0, 0, 32'd0);
    send_cmd(CMD_UPDATE, 0, 0, 0, 32'd0);
    send_cmd(CMD_READ, 0, 0, 0, 32'd0);
  endtask

  task automatic test_random_phases();
    logic [31:0] lvl;
    for (int p = 0; p < 12; p++) begin
      lvl = ($urandom_range(0, 3) == 0) ? 32'hFFF0_0000 : $urandom_range(0, 32'h0040_0000);
      set_config(lvl, ($urandom_range(0, 4) == 0) ? 16'hFFFF : $urandom_range(0, 16'hFFFF),
                 mode_t'(p % 4), $urandom_range(0, 255), $urandom_range(1, 17),
                 (p % 3 == 0) ? 5'd16 : $urandom_range(1, 16));
      no_idle = (p % 5 == 4);
      send_cmd(CMD_INIT, 0, 0, 0, 32'd0);
      repeat (35) random_item();
    end
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    long_hold = 400;
    repeat (20) random_item();
    wait_idle();
    repeat (15) random_item();
  endtask

  always @(posedge clk) begin
    if (long_hold > 0) begin
      out_ready <= 1'b0;
      long_hold--;
    end else if (ready_gap > 0) begin
      out_ready <= 1'b0;
      ready_gap--;
    end else begin
      out_ready <= 1'b1;
      ready_gap = gap_len();
    end
  end

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: trail_value %h", out_item.trail_value);
        errors++;
      end else begin
        exp_item = expected_q.pop_front();
        n_checked++;
        if (out_item.trail_value !== exp_item.trail_value) begin
          $error("trail_value expected %h actual %h", exp_item.trail_value,
                 out_item.trail_value);
          errors++;
        end
        if (out_item.done_res !== exp_item.done_res) begin
          $error("done_res expected %b actual %b", exp_item.done_res, out_item.done_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cur_cfg = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_setup();
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_idle();
    repeat (100) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d transactions never arrived", expected_q.size());
      errors++;
    end
    $display("ran %0d commands (%0d table updates), checked %0d results, %0d errors",
             n_sent, n_updates, n_checked, errors);
    $display("covered all four deposit modes, saturation, out-of-range loads and reads");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
src/aco_pkg.sv
src/aco_ram.sv
src/aco_front.sv
src/aco_back.sv
src/aco_pheromone_update.sv
tb/tb_aco_pheromone_update.sv
